// File: design/swmmm_pkg.sv
// shared types and constants for the stack with min, max and mean
package swmmm_pkg;

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_STATS = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  localparam logic [4:0] CAP_RESET = 5'd16;

  localparam logic signed [31:0] POP_EMPTY_VALUE = -32'sd1;
  localparam int MEAN_FRAC_BITS = 8;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] value;
  } swmmm_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] popped_value;
    logic signed [31:0] max_value;
    logic signed [31:0] min_value;
    logic signed [39:0] mean_q8;
  } swmmm_out_t;

endpackage

// File: design/swmmm_ram.sv
// generic single write port, single read port ram with registered read
module swmmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/swmmm_accum.sv
// running max, min and sum over the words of a statistics walk
module swmmm_accum #(
  parameter int SW = 37
) (
  input  logic                 clk,
  input  logic                 clear,
  input  logic                 en,
  input  logic signed [31:0]   data,
  output logic signed [31:0]   max_value,
  output logic signed [31:0]   min_value,
  output logic signed [SW-1:0] sum
);

  always_ff @(posedge clk) begin
    if (clear) begin
      max_value <= 32'sh8000_0000;
      min_value <= 32'sh7fff_ffff;
      sum       <= '0;
    end else if (en) begin
      if (data > max_value) begin
        max_value <= data;
      end
      if (data < min_value) begin
        min_value <= data;
      end
      sum <= sum + SW'(data);
    end
  end

endmodule

// File: design/swmmm_div.sv
// restoring unsigned divider, one quotient bit per cycle
module swmmm_div #(
  parameter int NW = 44,
  parameter int DW = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int KW = $clog2(NW + 1);

  logic          busy;
  logic [KW-1:0] steps;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;
  logic          ge;

  assign rem_sh = {rem, quotient[NW-1]};
  assign diff   = rem_sh - {1'b0, dvs};
  assign ge     = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= KW'(NW);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == KW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      quotient <= {quotient[NW-2:0], ge};
    end
  end

endmodule

// File: design/stack_with_min_max_mean.sv
// top level of the bounded lifo stack with max, min and mean statistics
// A bounded lifo of signed 32-bit words held in a ram with a registered
// read port. Each input transaction carries push, pop or statistics and
// gives exactly one output transaction. Push (and the unused command)
// answers from idle, so pushes stream at one per cycle while the output
// is taken; pop adds ST_POP because the top word comes through the
// registered ram read. Statistics on a non-empty stack walks the stored
// words one per cycle through the ram port into a running max/min/sum
// unit, then a restoring divider forms sum*256/count one quotient bit per
// cycle; no new transaction is taken until its result is output. The
// capacity register (reset 16, clamped to DEPTH, zero means always full)
// is written through cfg_we/cfg_wdata; the user must write it only while
// the block is idle, which the block does not enforce. The ram needs no
// clearing after reset: only words below the count are read.
module stack_with_min_max_mean #(
  parameter int DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  swmmm_pkg::swmmm_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output swmmm_pkg::swmmm_out_t out_data,
  input  logic                  cfg_we,
  input  logic [4:0]            cfg_wdata
);

  import swmmm_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);          // count width, holds DEPTH
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = (CW > 5) ? CW : 5;          // compare width for limit
  localparam int SW = 32 + CW;                    // sum cannot overflow
  localparam int NW = SW - 1 + MEAN_FRAC_BITS;    // |sum| << 8

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_POP    = 3'd1;
  localparam logic [2:0] ST_WALK   = 3'd2;
  localparam logic [2:0] ST_SETTLE = 3'd3;
  localparam logic [2:0] ST_DIVGO  = 3'd4;
  localparam logic [2:0] ST_DIV    = 3'd5;

  logic [2:0]    state;
  logic [CW-1:0] count;
  logic [4:0]    capacity;
  logic [AW-1:0] idx;
  logic          acc_en;

  logic          accept;
  logic          out_take;
  logic          full;
  logic [LW-1:0] limit;
  logic [CW-1:0] count_m1;

  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  logic                 acc_clear;
  logic signed [31:0]   acc_max;
  logic signed [31:0]   acc_min;
  logic signed [SW-1:0] acc_sum;
  logic [SW-1:0]        sum_abs;
  logic                 sum_neg;

  logic          div_start;
  logic          div_done;
  logic [NW-1:0] div_q;
  logic [39:0]   q_low;

  // handshake: take a transaction only when idle and the output slot frees
  assign out_take = out_valid && out_ready;
  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  // capacity clamps to DEPTH; count at or above it means full
  assign limit    = (LW'(capacity) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(capacity);
  assign full     = LW'(count) >= limit;
  assign count_m1 = count - 1'b1;

  // push writes at the current count; pop reads one below it
  assign ram_we    = accept && (in_data.command == CMD_PUSH) && !full;
  assign ram_raddr = (state == ST_WALK) ? idx : count_m1[AW-1:0];

  swmmm_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (in_data.value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign acc_clear = accept && (in_data.command == CMD_STATS);

  swmmm_accum #(
    .SW (SW)
  ) u_accum (
    .clk       (clk),
    .clear     (acc_clear),
    .en        (acc_en),
    .data      (ram_rdata),
    .max_value (acc_max),
    .min_value (acc_min),
    .sum       (acc_sum)
  );

  // divide the magnitude, put the sign back after: truncation toward zero
  assign sum_neg   = acc_sum[SW-1];
  assign sum_abs   = sum_neg ? (SW'(0) - acc_sum) : acc_sum;
  assign div_start = (state == ST_DIVGO);

  swmmm_div #(
    .NW (NW),
    .DW (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({sum_abs[SW-2:0], {MEAN_FRAC_BITS{1'b0}}}),
    .divisor  (count),
    .done     (div_done),
    .quotient (div_q)
  );

  assign q_low = div_q[39:0];

  // control: state, count, capacity, walk index, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      capacity  <= CAP_RESET;
      idx       <= '0;
      acc_en    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (out_take) begin
        out_valid <= 1'b0;
      end
      acc_en <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (in_data.command)
              CMD_PUSH: begin
                if (!full) begin
                  count <= count + 1'b1;
                end
                out_valid <= 1'b1;
              end
              CMD_POP: begin
                if (count == '0) begin
                  out_valid <= 1'b1;
                end else begin
                  count <= count_m1;
                  state <= ST_POP;
                end
              end
              CMD_STATS: begin
                if (count == '0) begin
                  out_valid <= 1'b1;
                end else begin
                  idx   <= '0;
                  state <= ST_WALK;
                end
              end
              default: begin
                out_valid <= 1'b1;
              end
            endcase
          end
        end
        ST_POP: begin
          out_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        ST_WALK: begin
          // one ram read per cycle, summed in the following cycle
          acc_en <= 1'b1;
          idx    <= idx + 1'b1;
          if (CW'(idx) == count_m1) begin
            state <= ST_SETTLE;
          end
        end
        ST_SETTLE: begin
          state <= ST_DIVGO;
        end
        ST_DIVGO: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= '0;
      unique case (in_data.command)
        CMD_PUSH: begin
          out_data.status <= full ? STAT_FULL : STAT_OK;
        end
        CMD_POP: begin
          if (count == '0) begin
            out_data.status       <= STAT_EMPTY;
            out_data.popped_value <= POP_EMPTY_VALUE;
          end
        end
        CMD_STATS: begin
          if (count == '0) begin
            out_data.status <= STAT_EMPTY;
          end
        end
        default: begin
          out_data.status <= STAT_OK;
        end
      endcase
    end else if (state == ST_POP) begin
      out_data.popped_value <= ram_rdata;
    end else if ((state == ST_DIV) && div_done) begin
      out_data.max_value <= acc_max;
      out_data.min_value <= acc_min;
      out_data.mean_q8   <= sum_neg ? (40'sd0 - q_low) : q_low;
    end
  end

endmodule
